// ===== hdl/dlr_pkg.sv =====
// Shared constants and types for the dashed line rasterizer.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package dlr_pkg;

    // Fixed widths of the stream and configuration fields
    localparam int FIELD_W     = 8;
    localparam int DASH_W      = 8;
    localparam int COORD_W_DEF = 8;

    // Codes carried in the input tuser bit
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // latch a new line, start phase division
        logic step;      // advance one pixel
        logic out_load;  // capture the current pixel into the output register
        logic cfg_wr;    // write dash_mode, restart phase division
        logic div_step;  // one iteration of the dash phase divider
    } t_ctl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic line_active;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/dlr_datapath.sv =====
// Datapath: line setup, Bresenham stepping, dash phase tracking and output register.
// Depends on dlr_pkg; driven by dlr_ctrl commands.
`default_nettype none

module dlr_datapath #(
    parameter int COORD_WIDTH = dlr_pkg::COORD_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dlr_pkg::t_ctl_cmd             i_cmd,
    input  wire logic [dlr_pkg::FIELD_W-1:0]   i_start_x,
    input  wire logic [dlr_pkg::FIELD_W-1:0]   i_start_y,
    input  wire logic [dlr_pkg::FIELD_W-1:0]   i_end_x,
    input  wire logic [dlr_pkg::FIELD_W-1:0]   i_end_y,
    input  wire logic [dlr_pkg::DASH_W-1:0]    i_cfg_data,
    output dlr_pkg::t_dp_status                o_status,
    output logic [dlr_pkg::FIELD_W-1:0]        o_pixel_x,
    output logic [dlr_pkg::FIELD_W-1:0]        o_pixel_y,
    output logic                               o_draw,
    output logic                               o_last_pixel
);

    localparam int CW = COORD_WIDTH;
    localparam int EW = COORD_WIDTH + 2;
    localparam int DW = dlr_pkg::DASH_W;

    // line state
    logic [CW-1:0]        r_major_pos, r_minor_pos, r_major_stop;
    logic [CW-1:0]        r_major_delta, r_minor_delta;
    logic signed [EW-1:0] r_error;
    logic                 r_minor_down, r_swapped, r_active;
    // dash register and phase (remainder and quotient parity of major_pos / len)
    logic signed [DW-1:0] r_dash;
    logic [DW-1:0]        r_rem;
    logic                 r_q;
    logic [CW-1:0]        r_shift;
    // output register
    logic [dlr_pkg::FIELD_W-1:0] r_px, r_py;
    logic                        r_draw, r_last;

    // setup
    logic [CW-1:0] a0, b0, a1, b1, da, db;
    logic [CW-1:0] sa0, sb0, sa1, sb1, sda, sdb;
    logic [CW-1:0] na0, nb0, na1, nb1, nstop;
    logic          swap;
    // stepping
    logic                 last_now, draw_now;
    logic [CW-1:0]        px_now, py_now;
    logic signed [EW-1:0] err_sub, err_next;
    // dash phase
    logic [DW-1:0]        len;
    logic [DW:0]          div_t, phase_inc;
    logic                 div_ge, phase_wrap;
    logic [DW-1:0]        div_rem;

    always_comb begin
        a0 = CW'(i_start_x);
        b0 = CW'(i_start_y);
        a1 = CW'(i_end_x);
        b1 = CW'(i_end_y);
        da = (a0 > a1) ? a0 - a1 : a1 - a0;
        db = (b0 > b1) ? b0 - b1 : b1 - b0;
        swap = db > da;
        sa0 = swap ? b0 : a0;
        sb0 = swap ? a0 : b0;
        sa1 = swap ? b1 : a1;
        sb1 = swap ? a1 : b1;
        sda = swap ? db : da;
        sdb = swap ? da : db;
        // order so the major coordinate rises
        if (sa0 > sa1) begin
            na0 = sa1; nb0 = sb1; na1 = sa0; nb1 = sb0;
        end else begin
            na0 = sa0; nb0 = sb0; na1 = sa1; nb1 = sb1;
        end
        // pull in an end at the coordinate maximum
        nstop = (na1 == {CW{1'b1}}) ? na1 - 1'b1 : na1;
    end

    always_comb begin
        last_now = r_major_pos == r_major_stop;
        px_now   = r_swapped ? r_minor_pos : r_major_pos;
        py_now   = r_swapped ? r_major_pos : r_minor_pos;
        // solid, or drawn on even quotient (positive) / odd quotient (negative)
        draw_now = (r_dash == '0) | (r_q ^ ~r_dash[DW-1]);
        err_sub  = r_error - $signed({2'b00, r_minor_delta});
        err_next = err_sub[EW-1] ? err_sub + $signed({2'b00, r_major_delta}) : err_sub;
    end

    always_comb begin
        len        = r_dash[DW-1] ? DW'(-r_dash) : DW'(r_dash);
        div_t      = {r_rem, r_shift[CW-1]};
        div_ge     = div_t >= {1'b0, len};
        div_rem    = div_ge ? DW'(div_t - {1'b0, len}) : DW'(div_t);
        phase_inc  = {1'b0, r_rem} + 1'b1;
        phase_wrap = phase_inc == {1'b0, len};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_pos   <= '0;
            r_minor_pos   <= '0;
            r_major_stop  <= '0;
            r_major_delta <= '0;
            r_minor_delta <= '0;
            r_error       <= '0;
            r_minor_down  <= 1'b0;
            r_swapped     <= 1'b0;
            r_active      <= 1'b0;
            r_dash        <= '0;
            r_rem         <= '0;
            r_q           <= 1'b0;
            r_shift       <= '0;
        end else begin
            if (i_cmd.cfg_wr) begin
                r_dash  <= i_cfg_data;
                r_rem   <= '0;
                r_shift <= r_major_pos;
            end

            if (i_cmd.load) begin
                r_major_pos   <= na0;
                r_minor_pos   <= nb0;
                r_major_stop  <= nstop;
                r_major_delta <= sda;
                r_minor_delta <= sdb;
                r_error       <= EW'(sda >> 1);
                r_minor_down  <= !(nb1 > nb0);
                r_swapped     <= swap;
                r_active      <= na0 <= nstop;
                r_rem         <= '0;
                r_shift       <= na0;
            end else if (i_cmd.step && r_active) begin
                if (last_now) begin
                    r_active <= 1'b0;
                end else begin
                    r_error     <= err_next;
                    r_major_pos <= r_major_pos + 1'b1;
                    if (err_sub[EW-1]) begin
                        r_minor_pos <= r_minor_down ? r_minor_pos - 1'b1
                                                    : r_minor_pos + 1'b1;
                    end
                    // advance the dash phase with the major coordinate
                    if (phase_wrap) begin
                        r_rem <= '0;
                        r_q   <= ~r_q;
                    end else begin
                        r_rem <= DW'(phase_inc);
                    end
                end
            end

            if (i_cmd.div_step) begin
                r_rem   <= div_rem;
                r_q     <= div_ge;
                r_shift <= {r_shift[CW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_px   <= dlr_pkg::FIELD_W'(px_now);
            r_py   <= dlr_pkg::FIELD_W'(py_now);
            r_draw <= draw_now;
            r_last <= last_now;
        end
    end

    assign o_status.line_active = r_active;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_draw       = r_draw;
    assign o_last_pixel = r_last;

endmodule

`default_nettype wire

// ===== hdl/dlr_ctrl.sv =====
// Controller: handshakes, phase divider sequencing and output valid.
// Depends on dlr_pkg; commands dlr_datapath.
`default_nettype none

module dlr_ctrl #(
    parameter int COORD_WIDTH = dlr_pkg::COORD_W_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    input  wire logic                i_kind,
    output logic                     o_s_tready,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    input  wire dlr_pkg::t_dp_status i_status,
    output dlr_pkg::t_ctl_cmd        o_cmd
);

    localparam int CNT_W = $clog2(COORD_WIDTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             s_acc, cfg_acc;

    always_comb begin
        // configuration wins over a concurrent item
        o_cfg_ready = r_state == ST_IDLE;
        o_s_tready  = (r_state == ST_IDLE) && !i_cfg_valid && (!r_out_valid || i_m_tready);
        cfg_acc     = i_cfg_valid && o_cfg_ready;
        s_acc       = i_s_tvalid && o_s_tready;

        o_cmd.cfg_wr   = cfg_acc;
        o_cmd.load     = s_acc && (i_kind == dlr_pkg::KIND_LOAD);
        o_cmd.step     = s_acc && (i_kind == dlr_pkg::KIND_STEP);
        o_cmd.out_load = o_cmd.step && i_status.line_active;
        o_cmd.div_step = r_state == ST_DIV;

        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.cfg_wr || o_cmd.load) begin
                    n_state = ST_DIV;
                    n_cnt   = CNT_W'(COORD_WIDTH - 1);
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

// ===== hdl/dashed_line_rasterizer_core.sv =====
// Top level of the dashed line rasterizer: controller plus datapath.
// Depends on dlr_pkg, dlr_ctrl and dlr_datapath.
`default_nettype none

// Bresenham line rasterizer with dash patterns. Send a load transfer
// (tuser = 0) with both endpoints, then one step transfer (tuser = 1) per
// pixel; each step of an active line returns one pixel transfer carrying its
// coordinates, a draw flag in tuser and tlast on the final pixel. A step with
// no active line returns nothing. A load, and every write of dash_mode, is
// followed by a divide phase in which the block takes no input: a restoring
// divider, one quotient bit per cycle, works out the dash phase (major
// coordinate divided by the dash length) so that later steps can track it
// with a simple counter. dash_mode: 0 solid, 1 dotted, above 1 dashes of
// that length, negative for inverted dashes. A pending configuration
// transfer has priority over an input transfer in the same cycle.
module dashed_line_rasterizer_core #(
    parameter int COORD_WIDTH = dlr_pkg::COORD_W_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: start_x [7:0], start_y [15:8], end_x [23:16], end_y [31:24]
    input  wire logic [4*dlr_pkg::FIELD_W-1:0]     i_s_tdata,
    // tuser: kind [0]
    input  wire logic                              i_s_tuser,
    // output stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // tdata: pixel_x [7:0], pixel_y [15:8]
    output logic [2*dlr_pkg::FIELD_W-1:0]          o_m_tdata,
    // tuser: draw [0]
    output logic                                   o_m_tuser,
    output logic                                   o_m_tlast,
    // configuration write channel (dash_mode)
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [dlr_pkg::DASH_W-1:0]        i_cfg_data
);

    localparam int FW = dlr_pkg::FIELD_W;

    dlr_pkg::t_ctl_cmd   cmd;
    dlr_pkg::t_dp_status status;

    dlr_ctrl #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_kind      (i_s_tuser),
        .o_s_tready  (o_s_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dlr_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_start_x    (i_s_tdata[FW-1:0]),
        .i_start_y    (i_s_tdata[2*FW-1:FW]),
        .i_end_x      (i_s_tdata[3*FW-1:2*FW]),
        .i_end_y      (i_s_tdata[4*FW-1:3*FW]),
        .i_cfg_data   (i_cfg_data),
        .o_status     (status),
        .o_pixel_x    (o_m_tdata[FW-1:0]),
        .o_pixel_y    (o_m_tdata[2*FW-1:FW]),
        .o_draw       (o_m_tuser),
        .o_last_pixel (o_m_tlast)
    );

endmodule

`default_nettype wire
